// File: rtl/core/dpp_pkg.sv
// Package for the decimal percent text parser: parse phase codes, character
// constants, byte class helpers and the state and result structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpp_pkg;

  // Parse phase codes.
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_POSTWS = 3'd3;
  localparam logic [2:0] PH_ZEROS  = 3'd4;
  localparam logic [2:0] PH_TAILWS = 3'd5;
  localparam logic [2:0] PH_CLOSED = 3'd6;
  localparam logic [2:0] PH_ERROR  = 3'd7;

  // Characters that the grammar names.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HT    = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Value limits: the accumulator saturates one above the clamp.
  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [6:0] VAL_SAT = 7'd101;

  // Parser state except the byte count, whose width follows a parameter.
  typedef struct packed {
    logic [2:0] phase;
    logic       quote_opened;
    logic       quote_closed;
    logic       minus_seen;
    logic [6:0] value;
    logic       terminated;
  } dpp_state_t;

  localparam dpp_state_t STATE_CLEAR = '{
    phase: PH_LEAD, quote_opened: 1'b0, quote_closed: 1'b0,
    minus_seen: 1'b0, value: 7'd0, terminated: 1'b0
  };

  // One result as it leaves the parse logic.
  typedef struct packed {
    logic       valid;
    logic       accepted;
    logic [6:0] percent;
  } dpp_result_t;

  // Space, HT, LF, VT, FF and CR count as whitespace.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_HT) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dpp_if.sv
// Valid/ready channel interfaces for the parser's byte input and result output.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface dpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;
  logic       empty_message;

  modport source (output valid, output text_byte, output final_byte,
                  output empty_message, input ready);
  modport sink   (input valid, input text_byte, input final_byte,
                  input empty_message, output ready);
endinterface

interface dpp_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [6:0] percent;

  modport source (output valid, output accepted, output percent, input ready);
  modport sink   (input valid, input accepted, input percent, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dpp_step.sv
// Combinational parse step: next parser state and an optional result for one byte.
// Depends on dpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpp_step
  import dpp_pkg::*;
#(
  parameter int MAX_TEXT_BYTES = 15,
  parameter int CntW = $clog2(MAX_TEXT_BYTES + 2)
) (
  input  dpp_state_t      state,
  input  logic [CntW-1:0] count,
  input  logic [7:0]      text_byte,
  input  logic            final_byte,
  input  logic            empty_message,
  output dpp_state_t      state_next,
  output logic [CntW-1:0] count_next,
  output dpp_result_t     result
);

  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TEXT_BYTES);

  always_comb begin
    dpp_state_t      s;
    logic [CntW-1:0] cnt;
    logic            number_done;
    logic            ok;
    logic [9:0]      acc;

    s   = state;
    cnt = count;
    ok  = 1'b0;
    acc = 10'(state.value) * 10'd10 + 10'(text_byte[3:0]);
    number_done = (state.phase == PH_DIGITS) || (state.phase == PH_POSTWS) ||
                  (state.phase == PH_ZEROS) || (state.phase == PH_TAILWS);

    // Length count saturates one above the limit.
    if (cnt <= CntMax) begin
      cnt = cnt + 1'b1;
    end

    // Bytes past the limit or after a zero byte only count.
    if ((cnt <= CntMax) && !state.terminated) begin
      if (text_byte == CHAR_NUL) begin
        s.terminated = 1'b1;
      end else if (text_byte == CHAR_QUOTE) begin
        if ((state.phase == PH_LEAD) && !state.quote_opened && !state.minus_seen) begin
          s.quote_opened = 1'b1;
        end else if (number_done && state.quote_opened) begin
          s.quote_closed = 1'b1;
          s.phase        = PH_CLOSED;
        end else begin
          s.phase = PH_ERROR;
        end
      end else begin
        unique case (state.phase) inside
          PH_LEAD: begin
            if (is_blank(text_byte)) begin
              s.phase = PH_LEAD;
            end else if ((text_byte == CHAR_PLUS) || (text_byte == CHAR_MINUS)) begin
              s.minus_seen = (text_byte == CHAR_MINUS);
              s.phase      = PH_SIGN;
            end else if (is_digit(text_byte)) begin
              s.value = 7'(text_byte[3:0]);
              s.phase = PH_DIGITS;
            end else begin
              s.phase = PH_ERROR;
            end
          end
          PH_SIGN, PH_DIGITS: begin
            if (is_digit(text_byte)) begin
              s.value = (acc > 10'(PCT_MAX)) ? VAL_SAT : acc[6:0];
              s.phase = PH_DIGITS;
            end else if ((state.phase == PH_DIGITS) && is_blank(text_byte)) begin
              s.phase = PH_POSTWS;
            end else if ((state.phase == PH_DIGITS) && (text_byte == CHAR_DOT)) begin
              s.phase = PH_ZEROS;
            end else begin
              s.phase = PH_ERROR;
            end
          end
          PH_POSTWS: begin
            if (text_byte == CHAR_DOT) begin
              s.phase = PH_ZEROS;
            end else if (!is_blank(text_byte)) begin
              s.phase = PH_ERROR;
            end
          end
          PH_ZEROS: begin
            if (is_blank(text_byte)) begin
              s.phase = PH_TAILWS;
            end else if (text_byte != CHAR_ZERO) begin
              s.phase = PH_ERROR;
            end
          end
          PH_TAILWS, PH_CLOSED: begin
            if (!is_blank(text_byte)) begin
              s.phase = PH_ERROR;
            end
          end
          default: begin
            s.phase = PH_ERROR;
          end
        endcase
      end
    end

    // Verdict on the last byte, from the updated state.
    if (cnt <= CntMax) begin
      if (s.quote_opened) begin
        ok = (s.phase == PH_CLOSED) && s.quote_closed;
      end else begin
        ok = (s.phase == PH_DIGITS) || (s.phase == PH_POSTWS) ||
             (s.phase == PH_ZEROS) || (s.phase == PH_TAILWS);
      end
    end

    result.valid    = empty_message || final_byte;
    result.accepted = ok && !empty_message;
    result.percent  = (ok && !empty_message && !s.minus_seen) ?
                      ((s.value > PCT_MAX) ? PCT_MAX : s.value) : 7'd0;

    // Every result, and an empty message, returns the parser to its start.
    if (empty_message || final_byte) begin
      state_next = STATE_CLEAR;
      count_next = '0;
    end else begin
      state_next = s;
      count_next = cnt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dpp_out_reg.sv
// Result register: holds one result until the receiver takes it and tells the
// parser when a new byte can be taken. Depends on dpp_pkg and dpp_if.
`timescale 1ns / 1ps
`default_nettype none

module dpp_out_reg
  import dpp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  dpp_result_t   result,
  output logic          can_load,
  dpp_out_if.source     out_ch
);

  logic       valid;
  logic       accepted;
  logic [6:0] percent;

  // The slot is free when empty or emptied by a transfer in this cycle.
  assign can_load = !valid || out_ch.ready;

  // Valid flag: set by a loaded result, cleared by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load && result.valid;
    end
  end

  // Payload loads without reset.
  always_ff @(posedge clk) begin
    if (can_load && load && result.valid) begin
      accepted <= result.accepted;
      percent  <= result.percent;
    end
  end

  assign out_ch.valid    = valid;
  assign out_ch.accepted = accepted;
  assign out_ch.percent  = percent;

endmodule

`default_nettype wire

// File: rtl/core/decimal_percent_text_parser_unit.sv
// Top level of the decimal percent text parser: parser state registers, the
// parse step and the result register. Depends on dpp_pkg, dpp_if, dpp_step
// and dpp_out_reg.
//
// Usage:
//   in_ch carries one message byte per transfer with final_byte marking the
//   last byte; empty_message reports a message with no bytes at all.
//   out_ch carries one result (accepted, percent) per message, from the
//   transfer of its last byte or of an empty-message marker.
// Throughput and timing:
//   One byte is taken per cycle while no result waits. A result appears on
//   out_ch in the cycle after the transfer of the byte that causes it. The
//   parse state and the saturating accumulator update on that transfer.
// Stall behavior:
//   in_ch.ready stays high while the result register is empty or is being
//   emptied in the same cycle; while a result waits, input is held off.
// Reset:
//   The synchronous rst returns the parser to the leading whitespace phase
//   and empties the result register. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module decimal_percent_text_parser_unit
  import dpp_pkg::*;
#(
  parameter int MAX_TEXT_BYTES = 15
) (
  input  logic      clk,
  input  logic      rst,
  dpp_in_if.sink    in_ch,
  dpp_out_if.source out_ch
);

  localparam int CntW = $clog2(MAX_TEXT_BYTES + 2);

  dpp_state_t      state;
  dpp_state_t      state_next;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  dpp_result_t     result;
  logic            can_load;
  logic            take;

  assign in_ch.ready = can_load;
  assign take        = in_ch.valid && can_load;

  // Parse logic for the byte on the input channel.
  dpp_step #(
    .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
    .CntW           (CntW)
  ) u_step (
    .state          (state),
    .count          (count),
    .text_byte      (in_ch.text_byte),
    .final_byte     (in_ch.final_byte),
    .empty_message  (in_ch.empty_message),
    .state_next     (state_next),
    .count_next     (count_next),
    .result         (result)
  );

  // Parser state advances on each byte transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
      count <= '0;
    end else if (take) begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Result register toward the receiver.
  dpp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .result   (result),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  // A rejected result always reports zero.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.accepted) |-> (out_ch.percent == 7'd0))
    else $error("rejected result with nonzero percent");

  // The percentage never exceeds the clamp.
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.percent <= PCT_MAX))
    else $error("percent above clamp");

  // A last byte or empty marker yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (take && (in_ch.final_byte || in_ch.empty_message)) |=> out_ch.valid)
    else $error("result missing after last byte");

  // A byte in the middle of a message leaves a nonzero byte count.
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (take && !in_ch.final_byte && !in_ch.empty_message) |=> (count != '0))
    else $error("byte count did not advance");

endmodule

`default_nettype wire
